@@ src/pefa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel energy frame accumulator package
// Word formats, opcodes, register indexes and defaults shared by the block.
// ----------------------------------------------------------------------------
package pefa_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;
  localparam int unsigned SUM_BITS_DEF   = 32;

  localparam int unsigned PIXEL_W    = 6;
  localparam int unsigned ENERGY_W   = 20;
  localparam int unsigned RESULT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0]  CFG_WIDTH_IDX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_HEIGHT_IDX = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET  = 7'd64;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [PIXEL_W-1:0]  pixel_x;
    logic [PIXEL_W-1:0]  pixel_y;
    logic [ENERGY_W-1:0] hit_energy;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [RESULT_W-1:0] pixel_sum;
    logic                frame_error;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input word
    logic lookup;  // compute the pixel index and read the store
    logic finish;  // update the store and load the result register
    logic sweep;   // write zero at the clear counter and advance it
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_clear;    // the word on the input is a frame clear
    logic sweep_last;  // the clear counter points at the last entry
    logic out_free;    // the result register can take a word this cycle
  } sts_t;

endpackage

@@ src/pefa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel energy frame accumulator controller
// Sequences acceptance, store lookup, update and the clearing pass.
// ----------------------------------------------------------------------------
module pefa_ctrl import pefa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.load    = accept;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.in_clear ? ST_SWEEP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/pefa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel energy frame accumulator datapath
// Configuration registers, pixel store, saturating adder and result register.
// ----------------------------------------------------------------------------
module pefa_datapath import pefa_pkg::*; #(
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = MAX_HEIGHT_DEF,
  parameter int unsigned SumBits   = SUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_word_t              in_word_i,
  input  logic                  out_stall_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output out_word_t             out_word_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LogW  = $clog2(MaxWidth + 1);
  localparam int unsigned LogH  = $clog2(MaxHeight + 1);
  localparam int unsigned DimA  = (LogW > LogH) ? LogW : LogH;
  localparam int unsigned DimW  = (DimA > CFG_DATA_W) ? DimA : CFG_DATA_W;
  localparam int unsigned ProdW = PIXEL_W + DimW + 1;
  localparam int unsigned SatW  = ((SumBits > ENERGY_W) ? SumBits : ENERGY_W) + 1;
  localparam logic [SumBits-1:0] SumMax = '1;

  logic [CFG_DATA_W-1:0] cfg_width_q, cfg_height_q;
  logic [1:0]            op_q;
  logic [PIXEL_W-1:0]    x_q, y_q;
  logic [ENERGY_W-1:0]   energy_q;
  logic [AddrW-1:0]      idx_q, idx_d;
  logic                  in_range_q, in_range_d;
  logic [SumBits-1:0]    rdata_q;
  logic                  err_q, err_d;
  logic [AddrW-1:0]      clr_cnt_q;
  logic                  out_valid_q;
  out_word_t             out_word_q;
  logic [SumBits-1:0]    mem_q [Depth];

  logic [DimW-1:0]    w_ext, h_ext, w_eff, h_eff;
  logic [ProdW-1:0]   prod;
  logic [SatW-1:0]    sum_wide;
  logic [SumBits-1:0] add_sum;
  logic               res_status;
  logic [SumBits-1:0] res_sum;
  logic               fin_we;
  logic [SumBits-1:0] fin_wdata;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [SumBits-1:0] mem_wdata;

  // Register values above the store dimensions act as the dimensions.
  assign w_ext = DimW'(cfg_width_q);
  assign h_ext = DimW'(cfg_height_q);
  assign w_eff = (w_ext > DimW'(MaxWidth))  ? DimW'(MaxWidth)  : w_ext;
  assign h_eff = (h_ext > DimW'(MaxHeight)) ? DimW'(MaxHeight) : h_ext;

  assign in_range_d = (DimW'(x_q) < w_eff) && (DimW'(y_q) < h_eff);
  assign prod       = ProdW'(y_q) * ProdW'(w_eff) + ProdW'(x_q);
  assign idx_d      = AddrW'(prod);

  assign sum_wide = SatW'(rdata_q) + SatW'(energy_q);
  assign add_sum  = (sum_wide > SatW'(SumMax)) ? SumMax : SumBits'(sum_wide);

  always_comb begin
    res_status = 1'b0;
    res_sum    = '0;
    err_d      = err_q;
    fin_we     = 1'b0;
    fin_wdata  = '0;
    case (op_q)
      OP_ADD: begin
        if (in_range_q) begin
          fin_we    = 1'b1;
          fin_wdata = add_sum;
          res_sum   = add_sum;
        end else begin
          res_status = 1'b1;
          err_d      = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range_q) begin
          fin_we  = 1'b1;
          res_sum = rdata_q;
        end else begin
          res_status = 1'b1;
        end
      end
      OP_CLEAR: begin
        err_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign mem_we    = cmd_i.sweep || (cmd_i.finish && fin_we);
  assign mem_waddr = cmd_i.sweep ? clr_cnt_q : idx_q;
  assign mem_wdata = cmd_i.sweep ? '0 : fin_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rdata_q <= mem_q[idx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_word_i.opcode;
      x_q      <= in_word_i.pixel_x;
      y_q      <= in_word_i.pixel_y;
      energy_q <= in_word_i.hit_energy;
    end
    if (cmd_i.lookup) begin
      idx_q      <= idx_d;
      in_range_q <= in_range_d;
    end
    if (cmd_i.finish) begin
      out_word_q.status      <= res_status;
      out_word_q.pixel_sum   <= RESULT_W'(res_sum);
      out_word_q.frame_error <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_DIM_RESET;
      cfg_height_q <= CFG_DIM_RESET;
      err_q        <= 1'b0;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH_IDX:  cfg_width_q  <= cfg_data_i;
          CFG_HEIGHT_IDX: cfg_height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.finish) begin
        err_q <= err_d;
      end
      if (cmd_i.sweep) begin
        clr_cnt_q <= sts_o.sweep_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.in_clear   = (in_word_i.opcode == OP_CLEAR);
  assign sts_o.sweep_last = (clr_cnt_q == AddrW'(Depth - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ src/pixel_energy_frame_accumulator.sv @@
`timescale 1ns / 1ps
// An add, read or unused-opcode word passes acceptance, index/read and update steps in turn;
// the update step waits while a stalled result is held. No new word is taken until then.
// A frame clear zeroes all MaxWidth*MaxHeight store entries, one store entry a cycle.
// Reset: asynchronous, active low; afterwards a clearing pass over all MaxWidth*MaxHeight entries
// (4096 at defaults) zeroes the store with input stalled; configuration writes are taken.
// ----------------------------------------------------------------------------
// Pixel energy frame accumulator
// Adds detector hit energies into a saturating per-pixel frame store; also reads and clears it.
// ----------------------------------------------------------------------------
module pixel_energy_frame_accumulator import pefa_pkg::*; #(
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = MAX_HEIGHT_DEF,
  parameter int unsigned SumBits   = SUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel. Writes are always taken.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input word channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  // Result word channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // The configuration registers sit in the datapath and can be written at
  // any time, including during a clearing pass.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // The controller takes one word at a time. It walks through an index and
  // store read step, then an update step that writes the store and loads
  // the result register. The result register sits between the two sides, so
  // the next word can be accepted while a finished result is still waiting.
  // A frame clear, and reset, sweep the store one entry per cycle.
  pefa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the pixel store, the sticky frame error flag, the
  // saturating adder and the output register.
  pefa_datapath #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .SumBits   (SumBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  // Only one word is in flight: acceptance closes the input at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is still in flight");

  // An out-of-area result never carries a pixel sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |-> out_word_o.pixel_sum == '0)
    else $error("out-of-area result with nonzero pixel sum");

  // Outside a sweep, the store is only updated in the cycle that loads the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !cmd.sweep && !cmd.lookup)
    else $error("store update overlaps a sweep or lookup");
`endif

endmodule
